>>> rtl/core/olad_pkg.sv
// Shared types and constants for the ordered list block.
// Action and status codes, payload structs. No dependencies.
`timescale 1ns / 1ps

package olad_pkg;

	localparam int VALUE_W  = 32;
	localparam int POS_W    = 16;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 7;

	localparam logic [1:0] ACT_APPEND  = 2'd0;
	localparam logic [1:0] ACT_DEL_VAL = 2'd1;
	localparam logic [1:0] ACT_DEL_POS = 2'd2;
	localparam logic [1:0] ACT_DUMP    = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

	typedef struct packed {
		logic [1:0]                action;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] entry_value;
		logic                      last;
		logic [COUNT_W-1:0]        entry_count;
	} rsp_t;

endpackage

>>> rtl/core/olad_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module olad_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/olad_ctrl.sv
// Sequencer for the ordered list: scan, shift and dump over the entry RAM.
// Depends on olad_pkg for codes and payload types.
`timescale 1ns / 1ps

module olad_ctrl #(
	parameter int CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  olad_pkg::req_t              req,
	output logic                        res_valid,
	input  logic                        res_ready,
	output olad_pkg::rsp_t              res,
	output logic                        wr_en,
	output logic [$clog2(CAPACITY)-1:0] wr_addr,
	output logic [olad_pkg::VALUE_W-1:0] wr_data,
	output logic [$clog2(CAPACITY)-1:0] rd_addr,
	input  logic [olad_pkg::VALUE_W-1:0] rd_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_DUMP  = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]                          state_q, state_n;
	logic [AW-1:0]                       idx_q, idx_n;
	logic [CW-1:0]                       count_q, count_n;
	logic [olad_pkg::VALUE_W-1:0]        value_q, value_n;
	logic [olad_pkg::STATUS_W-1:0]       status_q, status_n;

	logic [CW-1:0]                       idx_nxt;
	logic                                adv_ok;
	logic [olad_pkg::POS_W-1:0]          pos_m1;
	logic [CW-1:0]                       p_nxt;

	assign idx_nxt = CW'(idx_q) + CW'(1);
	assign adv_ok  = (idx_nxt < count_q);
	assign pos_m1  = req.position - olad_pkg::POS_W'(1);
	assign p_nxt   = CW'(pos_m1[AW-1:0]) + CW'(1);

	always_comb begin
		state_n   = state_q;
		idx_n     = idx_q;
		count_n   = count_q;
		value_n   = value_q;
		status_n  = status_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		res.status      = status_q;
		res.entry_value = '0;
		res.last        = 1'b1;
		res.entry_count = olad_pkg::COUNT_W'(count_q);
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data;
		rd_addr = idx_q;

		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					value_n  = req.value;
					status_n = olad_pkg::STAT_OK;
					state_n  = S_RESP;
					case (req.action)
						olad_pkg::ACT_APPEND: begin
							if (count_q == CW'(CAPACITY)) begin
								status_n = olad_pkg::STAT_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = count_q[AW-1:0];
								wr_data = req.value;
								count_n = count_q + CW'(1);
							end
						end
						olad_pkg::ACT_DEL_VAL: begin
							if (count_q == '0) begin
								status_n = olad_pkg::STAT_EMPTY;
							end else begin
								rd_addr = '0;
								idx_n   = '0;
								state_n = S_SCAN;
							end
						end
						olad_pkg::ACT_DEL_POS: begin
							if (count_q == '0) begin
								status_n = olad_pkg::STAT_EMPTY;
							end else if (req.position == '0 ||
								req.position > olad_pkg::POS_W'(count_q)) begin
								status_n = olad_pkg::STAT_BADPOS;
							end else if (p_nxt == count_q) begin
								// tail entry: nothing to move
								count_n = count_q - CW'(1);
							end else begin
								rd_addr = p_nxt[AW-1:0];
								idx_n   = p_nxt[AW-1:0];
								state_n = S_SHIFT;
							end
						end
						default: begin
							if (count_q == '0) begin
								status_n = olad_pkg::STAT_EMPTY;
							end else begin
								rd_addr = '0;
								idx_n   = '0;
								state_n = S_DUMP;
							end
						end
					endcase
				end
			end
			S_SCAN: begin
				// rd_data holds entry idx_q; prefetch the next one
				rd_addr = adv_ok ? idx_nxt[AW-1:0] : idx_q;
				if (rd_data == value_q) begin
					if (adv_ok) begin
						idx_n   = idx_nxt[AW-1:0];
						state_n = S_SHIFT;
					end else begin
						count_n = count_q - CW'(1);
						state_n = S_RESP;
					end
				end else if (adv_ok) begin
					idx_n = idx_nxt[AW-1:0];
				end else begin
					status_n = olad_pkg::STAT_NOTFOUND;
					state_n  = S_RESP;
				end
			end
			S_SHIFT: begin
				// move entry idx_q down one slot; read and write never share an entry
				wr_en   = 1'b1;
				wr_addr = idx_q - AW'(1);
				wr_data = rd_data;
				if (adv_ok) begin
					rd_addr = idx_nxt[AW-1:0];
					idx_n   = idx_nxt[AW-1:0];
				end else begin
					count_n = count_q - CW'(1);
					state_n = S_RESP;
				end
			end
			S_DUMP: begin
				res_valid       = 1'b1;
				res.status      = olad_pkg::STAT_OK;
				res.entry_value = rd_data;
				res.last        = !adv_ok;
				if (res_ready) begin
					if (adv_ok) begin
						rd_addr = idx_nxt[AW-1:0];
						idx_n   = idx_nxt[AW-1:0];
					end else begin
						state_n = S_IDLE;
					end
				end
			end
			S_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_n;
		value_q  <= value_n;
		status_q <= status_n;
	end

endmodule

>>> rtl/core/ordered_list_append_delete.sv
// Ordered list top level: entry RAM, sequencer and result register.
// Depends on olad_pkg, olad_ram and olad_ctrl.
// Append, rejected ops and an empty dump go straight from idle to the result state;
// delete by value scans up to the match, then shifts the rest, one RAM access each
// cycle; delete by position shifts the entries above pos. Dump: one entry per cycle
// while the output is not stalled, read from the RAM read port. The next request is
// taken only after the last result has entered the output register. Reset clears the count
// and sequencer; the RAM is not cleared.
`timescale 1ns / 1ps

module ordered_list_append_delete #(
	parameter int CAPACITY = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  olad_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output olad_pkg::rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);

	logic                         res_valid;
	logic                         res_ready;
	olad_pkg::rsp_t               res;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [olad_pkg::VALUE_W-1:0] wr_data;
	logic [AW-1:0]                rd_addr;
	logic [olad_pkg::VALUE_W-1:0] rd_data;

	logic                         out_valid_q;
	olad_pkg::rsp_t               out_q;

	// Entries live only in the RAM; data read from cells at or above the count is never used.
	olad_ram #(
		.WIDTH(olad_pkg::VALUE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	olad_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	// Output register: the sequencer may hand over a new result while the
	// current one is being taken, so a dump streams one entry per cycle while rsp_ready is high.
	assign res_ready = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
